>>> hw/rtl/sfc_pkg.sv
`timescale 1ns / 1ps
// Package for the serial frame checker: constants, status codes, shared structs
// and the byte-wise reflected CRC-16 update. No dependencies.
package sfc_pkg;

  localparam int unsigned    LenW          = 8;
  localparam logic [LenW-1:0] MaxFrameBytes = 8'd128;
  localparam logic [LenW-1:0] KeyMinBytes   = 8'd4;
  localparam logic [LenW-1:0] CrcMinBytes   = 8'd2;

  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [15:0] CrcInitReset = 16'hFFFF;
  localparam logic [7:0]  ByteCr       = 8'h0D;
  localparam logic [7:0]  ByteLf       = 8'h0A;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  // Word select bit of paddr
  localparam logic RegFrameMode = 1'b0;
  localparam logic RegCrcInit   = 1'b1;

  localparam logic ModeKey = 1'b0;
  localparam logic ModeCrc = 1'b1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StMismatch = 3'd1;
  localparam logic [2:0] StNoCrLf   = 3'd2;
  localparam logic [2:0] StTooShort = 3'd3;
  localparam logic [2:0] StTooLong  = 3'd4;

  localparam int unsigned OutDataW = 48;

  typedef struct packed {
    logic        frame_mode;
    logic [15:0] crc_init;
  } sfc_cfg_t;

  typedef struct packed {
    logic [LenW-1:0] frame_length;
    logic [15:0]     received_check;
    logic [15:0]     computed_check;
    logic [2:0]      status;
  } sfc_result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/sfc_regs.sv
`timescale 1ns / 1ps
// APB register file of the serial frame checker: frame_mode and crc_init.
// Depends on sfc_pkg.
module sfc_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [sfc_pkg::AddrW-1:0] paddr,
  input  logic [sfc_pkg::DataW-1:0] pwdata,
  output logic [sfc_pkg::DataW-1:0] prdata,
  output logic                   pready,
  output sfc_pkg::sfc_cfg_t      cfg_o
);
  import sfc_pkg::*;

  logic        mode_q;
  logic [15:0] init_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeKey;
      init_q <= CrcInitReset;
    end else if (wr_en) begin
      if (paddr[2] == RegFrameMode) begin
        mode_q <= pwdata[0];
      end else begin
        init_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      RegFrameMode: prdata = {{(DataW-1){1'b0}}, mode_q};
      RegCrcInit:   prdata = {{(DataW-16){1'b0}}, init_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.frame_mode = mode_q;
  assign cfg_o.crc_init   = init_q;

endmodule

>>> hw/rtl/sfc_engine.sv
`timescale 1ns / 1ps
// Frame state of the checker: tail window, byte sum, CRC, count and the
// per-frame verdict. Depends on sfc_pkg.
module sfc_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  sfc_pkg::sfc_cfg_t     cfg_i,
  output sfc_pkg::sfc_result_t  res_o
);
  import sfc_pkg::*;

  logic [7:0]      win_q [4];
  logic [7:0]      win_n [4];
  logic [15:0]     crc_q, crc_n, crc_base;
  logic [15:0]     sum_q, sum_n;
  logic [LenW-1:0] cnt_q, cnt_n;
  logic            over_q, over_n;
  logic [15:0]     crc_swap;

  always_comb begin
    win_n    = win_q;
    crc_base = (cnt_q == '0) ? cfg_i.crc_init : crc_q;
    crc_n    = crc_q;
    sum_n    = sum_q;
    cnt_n    = cnt_q;
    over_n   = over_q;
    if (cnt_q >= MaxFrameBytes) begin
      over_n = 1'b1;
    end else begin
      crc_n    = (cnt_q >= CrcMinBytes) ? crc_feed(crc_base, win_q[1]) : crc_base;
      sum_n    = (cnt_q >= KeyMinBytes) ? sum_q + {8'h00, win_q[3]} : sum_q;
      win_n[3] = win_q[2];
      win_n[2] = win_q[1];
      win_n[1] = win_q[0];
      win_n[0] = byte_i;
      cnt_n    = cnt_q + 1'b1;
    end
  end

  assign crc_swap = {crc_n[7:0], crc_n[15:8]};

  always_comb begin
    res_o.frame_length   = cnt_n;
    res_o.computed_check = '0;
    res_o.received_check = '0;
    if (over_n) begin
      res_o.status = StTooLong;
    end else if (cfg_i.frame_mode == ModeKey) begin
      if (cnt_n < KeyMinBytes) begin
        res_o.status = StTooShort;
      end else begin
        res_o.computed_check = sum_n;
        res_o.received_check = {win_n[3], win_n[2]};
        if (win_n[1] != ByteCr || win_n[0] != ByteLf) begin
          res_o.status = StNoCrLf;
        end else begin
          res_o.status = (sum_n == {win_n[3], win_n[2]}) ? StOk : StMismatch;
        end
      end
    end else begin
      if (cnt_n < CrcMinBytes) begin
        res_o.status = StTooShort;
      end else begin
        res_o.computed_check = crc_swap;
        res_o.received_check = {win_n[1], win_n[0]};
        res_o.status = (crc_swap == {win_n[1], win_n[0]}) ? StOk : StMismatch;
      end
    end
  end

  // Clear the frame state after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '{default: 8'h00};
      crc_q  <= CrcInitReset;
      sum_q  <= '0;
      cnt_q  <= '0;
      over_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        win_q  <= '{default: 8'h00};
        crc_q  <= cfg_i.crc_init;
        sum_q  <= '0;
        cnt_q  <= '0;
        over_q <= 1'b0;
      end else begin
        win_q  <= win_n;
        crc_q  <= crc_n;
        sum_q  <= sum_n;
        cnt_q  <= cnt_n;
        over_q <= over_n;
      end
    end
  end

endmodule

>>> hw/rtl/serial_frame_checker_core.sv
`timescale 1ns / 1ps
// Top level of the serial frame checker: input register, frame engine,
// result register and APB registers. Depends on sfc_pkg, sfc_regs, sfc_engine.

// The checker takes one received byte per clock on the slave stream (tlast on
// the final byte of a frame) and emits one status item per frame on the master
// stream, via the input register and then the result register. In key mode
// (frame_mode 0) a frame is body, sum high, sum low, CR, LF and the 16-bit
// byte sum of the body must match; in CRC mode (frame_mode 1) a frame is body,
// CRC low, CRC high and a reflected CRC-16 (poly 0xA001, start value crc_init)
// over the body must match. Frames longer than 128 bytes report too long,
// frames shorter than four bytes (key) or two bytes (CRC) report too short.
// Throughput is one byte per cycle: the CRC byte update and the sum add run
// combinationally between the input register and the result register. Only a
// final byte can wait, and only while the result register still holds a
// status that has not been taken. Write configuration between frames.
module serial_frame_checker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // last_byte
  // Status stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [18:3] computed_check, [34:19] received_check,
  // [42:35] frame_length, [47:43] zero
  output logic [sfc_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfc_pkg::AddrW-1:0]     paddr,
  input  logic [sfc_pkg::DataW-1:0]     pwdata,
  output logic [sfc_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import sfc_pkg::*;

  sfc_cfg_t    cfg;
  sfc_result_t res;
  sfc_result_t out_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       advance;

  sfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Hold a final byte while the previous status is still waiting
  assign advance       = in_valid_q & (~in_last_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  sfc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Load a status on each final byte, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(sfc_result_t)){1'b0}}, out_q};

  // Input side stalls only behind a final byte blocked by a waiting status
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked final byte");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.frame_length <= MaxFrameBytes))
    else $error("frame length above maximum");

  a_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == StTooLong || out_q.status == StTooShort))
      |-> (out_q.computed_check == '0 && out_q.received_check == '0))
    else $error("check fields not cleared on length error");

  a_ok_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == StOk) |-> (out_q.computed_check == out_q.received_check))
    else $error("ok status with unequal check values");

endmodule

>>> tb/sv/serial_frame_checker_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_frame_checker_core: directed byte table, then
// random frames in both modes under several idling styles. Depends on sfc_pkg.
module serial_frame_checker_core_tb;
  import sfc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseBytes  = 245;
  localparam int unsigned HoldCycles  = 300;
  // Frame mode of each random phase, phase 0 in bit 0
  localparam logic [NumPhases-1:0] PhaseModes = 8'b1101_0110;

  localparam logic [AddrW-1:0] AddrMode = {RegFrameMode, 2'b00};
  localparam logic [AddrW-1:0] AddrInit = {RegCrcInit, 2'b00};

  localparam sfc_result_t NoStatus = '0;

  // One row of the directed table: the mode it runs in, the byte, tlast, and
  // a hand-written status item where one is easy to read off.
  typedef struct packed {
    logic        mode;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    sfc_result_t res;
  } byte_row_t;

  localparam int unsigned DirLen = 27;
  localparam byte_row_t DirRows [DirLen] = '{
    // Key mode straight out of reset: a lone byte is too short
    {ModeKey, 8'hFF, 1'b1, 1'b1, {8'd1, 16'h0000, 16'h0000, StTooShort}},
    // Body 01 02, sum 0003, CR LF
    {ModeKey, 8'h01, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h02, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h00, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h03, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteCr, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteLf, 1'b1, 1'b1, {8'd6, 16'h0003, 16'h0003, StOk}},
    // Shortest key frame: empty body
    {ModeKey, 8'h00, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h00, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteCr, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteLf, 1'b1, 1'b1, {8'd4, 16'h0000, 16'h0000, StOk}},
    // Sum 00FF against a received 1234
    {ModeKey, 8'hFF, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h12, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h34, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteCr, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteLf, 1'b1, 1'b1, {8'd5, 16'h1234, 16'h00FF, StMismatch}},
    // Good sum but the frame ends in CR 0B
    {ModeKey, 8'h80, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h00, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h80, 1'b0, 1'b0, NoStatus},
    {ModeKey, ByteCr, 1'b0, 1'b0, NoStatus},
    {ModeKey, 8'h0B, 1'b1, 1'b1, {8'd5, 16'h0080, 16'h0080, StNoCrLf}},
    // CRC mode: one byte is too short
    {ModeCrc, 8'h00, 1'b1, 1'b1, {8'd1, 16'h0000, 16'h0000, StTooShort}},
    // Empty body: the check is the start value FFFF itself
    {ModeCrc, 8'hFF, 1'b0, 1'b0, NoStatus},
    {ModeCrc, 8'hFF, 1'b1, 1'b1, {8'd2, 16'hFFFF, 16'hFFFF, StOk}},
    // One body byte, check left to the predictor
    {ModeCrc, 8'h01, 1'b0, 1'b0, NoStatus},
    {ModeCrc, 8'hAA, 1'b0, 1'b0, NoStatus},
    {ModeCrc, 8'h55, 1'b1, 1'b0, NoStatus}
  };

  typedef enum int unsigned {
    FrGood, FrBadCheck, FrBadTail, FrShort, FrNoise, FrTooLong
  } frame_kind_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'h00;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [AddrW-1:0]      paddr         = '0;
  logic [DataW-1:0]      pwdata        = '0;
  logic [DataW-1:0]      prdata;
  logic                  pready;

  serial_frame_checker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Status items still owed by the block, oldest first
  sfc_result_t pending_status [$];

  int unsigned mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned status_seen  = 0;
  int unsigned cycles       = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_trigger = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  // Predictor copy of the frame state and the two registers
  logic [7:0]  tail [4];
  logic [15:0] crc_acc;
  logic [15:0] sum_acc;
  logic [7:0]  byte_cnt;
  logic        overrun;
  logic        model_mode;
  logic [15:0] model_init;

  // Reflected CRC-16, one byte, least significant bit first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_frame_state();
    for (int k = 0; k < 4; k++) tail[k] = 8'h00;
    crc_acc  = model_init;
    sum_acc  = 16'h0000;
    byte_cnt = '0;
    overrun  = 1'b0;
  endfunction

  // Advance the frame state by one accepted byte; return 1 with the frame
  // status when the byte closes the frame.
  function automatic bit predict_frame_status(input logic [7:0] b, input logic l,
                                              output sfc_result_t res);
    res = '0;
    if (byte_cnt >= MaxFrameBytes) begin
      overrun = 1'b1;
    end else begin
      if (byte_cnt == 0) crc_acc = model_init;
      // The sum trails the input by four bytes, the CRC by two
      if (byte_cnt >= 4) sum_acc = sum_acc + {8'h00, tail[3]};
      if (byte_cnt >= 2) crc_acc = crc16_update(crc_acc, tail[1]);
      tail[3]  = tail[2];
      tail[2]  = tail[1];
      tail[1]  = tail[0];
      tail[0]  = b;
      byte_cnt = byte_cnt + 1'b1;
    end
    if (!l) return 1'b0;
    res.frame_length = byte_cnt;
    if (overrun) begin
      res.status = StTooLong;
    end else if (model_mode == ModeKey) begin
      if (byte_cnt < KeyMinBytes) begin
        res.status = StTooShort;
      end else begin
        res.computed_check = sum_acc;
        res.received_check = {tail[3], tail[2]};
        if (tail[1] != ByteCr || tail[0] != ByteLf) res.status = StNoCrLf;
        else res.status = (sum_acc == res.received_check) ? StOk : StMismatch;
      end
    end else begin
      if (byte_cnt < CrcMinBytes) begin
        res.status = StTooShort;
      end else begin
        res.computed_check = {crc_acc[7:0], crc_acc[15:8]};
        res.received_check = {tail[1], tail[0]};
        res.status = (res.computed_check == res.received_check) ? StOk : StMismatch;
      end
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Status side: check every accepted item against the oldest expectation,
  // then pick tready for the next cycle. A hold request from the stimulus
  // keeps tready low for a long stretch, counted here.
  always @(posedge clk_i) begin
    sfc_result_t got_res;
    sfc_result_t want_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        status_seen++;
        got_res = m_axis_tdata[$bits(sfc_result_t)-1:0];
        if (pending_status.size() == 0) begin
          $error("status item with nothing expected: 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want_res = pending_status.pop_front();
          check_field("status", 32'(want_res.status), 32'(got_res.status));
          check_field("computed_check", 32'(want_res.computed_check),
                      32'(got_res.computed_check));
          check_field("received_check", 32'(want_res.received_check),
                      32'(got_res.received_check));
          check_field("frame_length", 32'(want_res.frame_length),
                      32'(got_res.frame_length));
          check_field("tdata padding", 0,
                      32'(m_axis_tdata[OutDataW-1:$bits(sfc_result_t)]));
        end
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d status items outstanding", cycles,
               pending_status.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one byte, wait for the handshake, then feed it to the predictor.
  // A typed row replaces the predicted status with the hand-written one.
  task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                           input sfc_result_t typed_res);
    sfc_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (l) frames_sent++;
    if (predict_frame_status(b, l, res)) pending_status.push_back(typed ? typed_res : res);
  endtask

  // Hold the input until every status has come out, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One APB transfer, after which the bus returns to idle
  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register, mirror it into the predictor and read it back
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [15:0] value);
    logic [DataW-1:0] rdata;
    apb_access(1'b1, addr, {16'h0000, value}, rdata);
    if (addr == AddrMode) model_mode = value[0];
    else model_init = value;
    apb_access(1'b0, addr, '0, rdata);
    check_field(addr == AddrMode ? "frame_mode readback" : "crc_init readback",
                addr == AddrMode ? {31'd0, model_mode} : {16'd0, model_init}, rdata);
  endtask

  // Build one random frame for the current mode and send it. Most frames are
  // well formed with random bodies; the rest break the check, the tail or
  // the length limits.
  task automatic send_random_frame();
    logic [7:0]  bytes_q [$];
    logic [15:0] chk;
    frame_kind_e kind;
    int unsigned pick;
    int unsigned body_len;
    int unsigned trailer;
    int unsigned idx;
    pick = $urandom_range(99);
    if (pick < 62) kind = FrGood;
    else if (pick < 72) kind = FrBadCheck;
    else if (pick < 80) kind = (model_mode == ModeKey) ? FrBadTail : FrBadCheck;
    else if (pick < 88) kind = FrShort;
    else if (pick < 97) kind = FrNoise;
    else kind = FrTooLong;
    trailer = (model_mode == ModeKey) ? 4 : 2;
    pick = $urandom_range(99);
    if (pick < 90) body_len = $urandom_range(12);
    else if (pick < 97) body_len = $urandom_range(60, 13);
    else body_len = MaxFrameBytes - trailer;   // exactly at the length limit
    case (kind)
      FrShort:   body_len = (model_mode == ModeKey) ? $urandom_range(3, 1) : 1;
      FrNoise:   body_len = $urandom_range(20, 1);
      FrTooLong: body_len = $urandom_range(MaxFrameBytes + 12, MaxFrameBytes + 1);
      default: ;
    endcase
    chk = (model_mode == ModeKey) ? 16'h0000 : model_init;
    for (int k = 0; k < body_len; k++) begin
      bytes_q.push_back(8'($urandom_range(255)));
      if (model_mode == ModeKey) chk = chk + {8'h00, bytes_q[k]};
      else chk = crc16_update(chk, bytes_q[k]);
    end
    if (kind == FrGood || kind == FrBadCheck || kind == FrBadTail) begin
      if (model_mode == ModeKey) begin
        bytes_q.push_back(chk[15:8]);
        bytes_q.push_back(chk[7:0]);
        bytes_q.push_back(ByteCr);
        bytes_q.push_back(ByteLf);
      end else begin
        bytes_q.push_back(chk[7:0]);
        bytes_q.push_back(chk[15:8]);
      end
      // Corrupt one check byte, or one of CR and LF
      idx = body_len + $urandom_range(1) + ((kind == FrBadTail) ? 2 : 0);
      if (kind != FrGood) bytes_q[idx] = bytes_q[idx] ^ 8'($urandom_range(255, 1));
    end
    for (int k = 0; k < bytes_q.size(); k++)
      push_byte(bytes_q[k], k == bytes_q.size() - 1, 1'b0, NoStatus);
  endtask

  initial begin
    logic [DataW-1:0] rdata;
    int unsigned      phase_end;
    model_mode = ModeKey;
    model_init = CrcInitReset;
    clear_frame_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Check the register reset values before anything is written
    apb_access(1'b0, AddrMode, '0, rdata);
    check_field("frame_mode after reset", {31'd0, ModeKey}, rdata);
    apb_access(1'b0, AddrInit, '0, rdata);
    check_field("crc_init after reset", {16'd0, CrcInitReset}, rdata);

    // Directed table; switch modes only with the pipe empty
    for (int i = 0; i < DirLen; i++) begin
      if (DirRows[i].mode != model_mode) begin
        drain();
        write_reg(AddrMode, {15'd0, DirRows[i].mode});
      end
      push_byte(DirRows[i].data, DirRows[i].last, DirRows[i].typed, DirRows[i].res);
    end

    // Random phases: idling style cycles through none, sender idle, receiver
    // stall and light idling on both sides; crc_init takes FFFF, 0000 or random.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_reg(AddrMode, {15'd0, PhaseModes[ph]});
      case (ph % 3)
        0:       write_reg(AddrInit, CrcInitReset);
        1:       write_reg(AddrInit, 16'h0000);
        default: write_reg(AddrInit, 16'($urandom_range(65535)));
      endcase
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
      endcase
      // Back up the status side while the sender offers bytes without idling
      if (ph == 0) hold_trigger++;
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_random_frame();
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_status.size() != 0) begin
      $error("%0d status items never arrived", pending_status.size());
      mismatches++;
    end
    $display("covered %0d bytes in %0d frames, %0d status items checked,",
             bytes_sent, frames_sent, status_seen);
    $display("both frame modes over %0d register settings, %0d mismatches",
             NumPhases + 1, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
